/* design/tbrl_pkg.sv */
// Shared constants for the token bucket rate limiter.
`timescale 1ns / 1ps

package tbrl_pkg;

   // Fixed-point scale of the token level: one whole token is 2^SCALE_SHIFT units
   localparam int unsigned SCALE_SHIFT = 20;
   localparam int unsigned CAP_W       = 16;
   localparam int unsigned LEVEL_W     = CAP_W + SCALE_SHIFT;
   localparam int unsigned TIME_W      = 64;
   localparam int unsigned RATE_W      = 32;
   localparam int unsigned COUNT_W     = 32;

   // Elapsed times at or above 2^SAT_SHIFT always fill the bucket when the rate is nonzero
   localparam int unsigned SAT_SHIFT   = LEVEL_W + SCALE_SHIFT;
   // Refill amount is clipped to one bit more than the level
   localparam int unsigned AMOUNT_W    = LEVEL_W + 1;
   // Product of the clipped elapsed time and the rate
   localparam int unsigned PROD_W      = SAT_SHIFT + RATE_W;

   localparam logic [LEVEL_W-1:0] SCALE_UNIT  = LEVEL_W'(1) << SCALE_SHIFT;
   localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(10);
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = {CAP_RESET, SCALE_SHIFT'(0)};

   // Configuration register indexes (byte address / 4)
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_RATE     = 2'd0;
   localparam logic [1:0] REG_CAPACITY = 2'd1;
   localparam logic [1:0] REG_BURST    = 2'd2;

endpackage

/* design/token_bucket_rate_limiter.sv */
// Token bucket rate limiter: refill, grant decision and statistics counters.
`timescale 1ns / 1ps

// Token bucket rate limiter.
// Request channel (req_valid / req_stall / req_now_ns): one beat is one acquire
// attempt stamped with a monotonic nanosecond time.
// Response channel (rsp_valid / rsp_stall / rsp_*): one beat per request, in order,
// carrying the grant, the burst flag, whole tokens left and the running totals.
// Configuration: APB-style port, rate at 0x0, capacity at 0x4, burst enable at 0x8;
// write only while no request is in flight.
// Path: a request beat passes the input register, then the result register.
// Throughput: one request per cycle while the response does not stall; the refill
// multiply, the saturating add and the grant compare are all combinational between
// the input register and the result register, since each item's refill depends
// on the level and refill time left by the one before it.
// Stall: while the response beat waits, the input register still takes one more
// request; after that req_stall rises until the response drains.
// Reset: the bucket is full (10 tokens), refill time and counters are zero, rate is
// zero, capacity is 10, bursts are enabled, and both channels are empty.
module token_bucket_rate_limiter (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [tbrl_pkg::TIME_W-1:0]          req_now_ns,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_granted,
   output logic                                 rsp_was_burst,
   output logic [tbrl_pkg::CAP_W-1:0]           rsp_tokens_whole,
   output logic [tbrl_pkg::COUNT_W-1:0]         rsp_allowed_total,
   output logic [tbrl_pkg::COUNT_W-1:0]         rsp_denied_total,
   output logic [tbrl_pkg::COUNT_W-1:0]         rsp_burst_total,
   // configuration port
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tbrl_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   localparam int unsigned LW = tbrl_pkg::LEVEL_W;
   localparam int unsigned SS = tbrl_pkg::SCALE_SHIFT;
   localparam int unsigned TW = tbrl_pkg::TIME_W;
   localparam int unsigned RW = tbrl_pkg::RATE_W;
   localparam int unsigned CW = tbrl_pkg::COUNT_W;
   localparam int unsigned AW = tbrl_pkg::AMOUNT_W;
   localparam int unsigned PW = tbrl_pkg::PROD_W;
   localparam int unsigned ST = tbrl_pkg::SAT_SHIFT;
   localparam int unsigned HW = ST - 32;

   // configuration registers
   logic [RW-1:0]                rate_ff;
   logic [tbrl_pkg::CAP_W-1:0]   cap_ff;
   logic                         burst_en_ff;
   logic                         csr_write;

   // pipeline registers
   logic                         in_valid_ff;
   logic [TW-1:0]                in_now_ff;
   logic                         rsp_valid_ff;
   logic                         rsp_granted_ff;
   logic                         rsp_burst_ff;

   // bucket state
   logic [LW-1:0]                level_ff;
   logic [LW-1:0]                level_in;
   logic [TW-1:0]                last_ff;
   logic [TW-1:0]                last_in;
   logic [CW-1:0]                allowed_ff;
   logic [CW-1:0]                denied_ff;
   logic [CW-1:0]                burst_cnt_ff;

   // datapath
   logic                         out_free;
   logic                         fire;
   logic                         time_ahead;
   logic [TW-1:0]                elapsed;
   logic                         elapsed_big;
   logic [63:0]                  pp_lo;
   logic [HW+RW-1:0]             pp_hi;
   logic [PW-1:0]                prod;
   logic [PW-SS-1:0]             amount_wide;
   logic [AW-1:0]                amount;
   logic                         amount_zero;
   logic                         do_refill;
   logic [LW-1:0]                top;
   logic [AW:0]                  sum;
   logic [LW-1:0]                level_refill;
   logic                         grant;
   logic                         burst;

   // Configuration write and read
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff     <= '0;
         cap_ff      <= tbrl_pkg::CAP_RESET;
         burst_en_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            tbrl_pkg::REG_RATE:     rate_ff     <= pwdata;
            tbrl_pkg::REG_CAPACITY: cap_ff      <= pwdata[tbrl_pkg::CAP_W-1:0];
            tbrl_pkg::REG_BURST:    burst_en_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         tbrl_pkg::REG_RATE:     prdata = rate_ff;
         tbrl_pkg::REG_CAPACITY: prdata = 32'(cap_ff);
         tbrl_pkg::REG_BURST:    prdata = 32'(burst_en_ff);
         default:                prdata = '0;
      endcase
   end

   // Handshake: the result register frees when empty or drained this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Input register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_now_ff <= req_now_ns;
      end
   end

   // Elapsed time since the last refill
   assign time_ahead  = in_now_ff > last_ff;
   assign elapsed     = in_now_ff - last_ff;
   assign elapsed_big = (|elapsed[TW-1:ST]) && (|rate_ff);

   // Refill product as two partial products over the clipped elapsed time
   assign pp_lo       = 64'(elapsed[31:0]) * 64'(rate_ff);
   assign pp_hi       = (HW+RW)'(elapsed[ST-1:32]) * (HW+RW)'(rate_ff);
   assign prod        = PW'(pp_lo) + {pp_hi, 32'b0};
   assign amount_wide = prod[PW-1:SS];

   // Clip the amount: anything at or above 2^LEVEL_W fills any bucket
   assign amount      = (elapsed_big || (|amount_wide[PW-SS-1:AW])) ?
                        '1 : amount_wide[AW-1:0];
   assign amount_zero = !elapsed_big && (amount_wide == '0);
   assign do_refill   = time_ahead && !amount_zero;

   // Saturating add against the bucket maximum
   assign top = {cap_ff, SS'(0)};
   assign sum = (AW+1)'(level_ff) + (AW+1)'(amount);

   always_comb begin
      if (!do_refill) begin
         level_refill = level_ff;
      end else if (sum >= (AW+1)'(top)) begin
         level_refill = top;
      end else begin
         level_refill = sum[LW-1:0];
      end
   end

   // Grant one whole token; burst when bursts are enabled and above half the maximum
   assign grant    = |level_refill[LW-1:SS];
   assign burst    = grant && burst_en_ff && (level_refill > {1'b0, top[LW-1:1]});
   assign level_in = grant ? (level_refill - tbrl_pkg::SCALE_UNIT) : level_refill;
   assign last_in  = do_refill ? in_now_ff : last_ff;

   // Advance bucket state and counters on each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= tbrl_pkg::LEVEL_RESET;
         last_ff      <= '0;
         allowed_ff   <= '0;
         denied_ff    <= '0;
         burst_cnt_ff <= '0;
      end else if (fire) begin
         level_ff     <= level_in;
         last_ff      <= last_in;
         allowed_ff   <= allowed_ff + CW'(grant);
         denied_ff    <= denied_ff + CW'(!grant);
         burst_cnt_ff <= burst_cnt_ff + CW'(burst);
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_granted_ff <= grant;
         rsp_burst_ff   <= burst;
      end
   end

   // Level and counters only change on a processed beat, so they track the
   // held result exactly
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_granted       = rsp_granted_ff;
   assign rsp_was_burst     = rsp_burst_ff;
   assign rsp_tokens_whole  = level_ff[LW-1:SS];
   assign rsp_allowed_total = allowed_ff;
   assign rsp_denied_total  = denied_ff;
   assign rsp_burst_total   = burst_cnt_ff;

   // Every processed beat bumps exactly one of allowed and denied
   a_one_count: assert property (@(posedge clock) disable iff (reset)
      fire |=> (allowed_ff + denied_ff) == ($past(allowed_ff + denied_ff) + CW'(1)))
      else $error("allowed plus denied did not advance by one");

   // A burst is always a grant
   a_burst_granted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_burst_ff |-> rsp_granted_ff)
      else $error("burst reported without grant");

   // A processed beat lands in the result register
   a_fire_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed beat lost");

   // Refill time never moves when time did not advance
   a_time_kept: assert property (@(posedge clock) disable iff (reset)
      fire && !time_ahead |=> $stable(last_ff))
      else $error("refill time moved without time advancing");

endmodule

/* dv/tbrl_grant_checker.sv */
// Watches the rate limiter's channels, predicts each attempt's outcome and compares.
`timescale 1ns / 1ps

module tbrl_grant_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [tbrl_pkg::TIME_W-1:0]     req_now_ns,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_granted,
   input  logic                            rsp_was_burst,
   input  logic [tbrl_pkg::CAP_W-1:0]      rsp_tokens_whole,
   input  logic [tbrl_pkg::COUNT_W-1:0]    rsp_allowed_total,
   input  logic [tbrl_pkg::COUNT_W-1:0]    rsp_denied_total,
   input  logic [tbrl_pkg::COUNT_W-1:0]    rsp_burst_total,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tbrl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   input  logic                            pready,
   output int                              mismatch_count,
   output int                              pending_count
);

   typedef struct packed {
      logic                         granted;
      logic                         was_burst;
      logic [tbrl_pkg::CAP_W-1:0]   tokens_whole;
      logic [tbrl_pkg::COUNT_W-1:0] allowed_total;
      logic [tbrl_pkg::COUNT_W-1:0] denied_total;
      logic [tbrl_pkg::COUNT_W-1:0] burst_total;
   } attempt_outcome_type;

   // Shadow registers
   logic [tbrl_pkg::RATE_W-1:0]  rate_cfg;
   logic [tbrl_pkg::CAP_W-1:0]   capacity_cfg;
   logic                         burst_cfg;

   // Shadow bucket state
   logic [tbrl_pkg::LEVEL_W-1:0] level;
   logic [tbrl_pkg::TIME_W-1:0]  refill_ns;
   logic [tbrl_pkg::COUNT_W-1:0] allowed_n;
   logic [tbrl_pkg::COUNT_W-1:0] denied_n;
   logic [tbrl_pkg::COUNT_W-1:0] burst_n;

   attempt_outcome_type outcome_q[$];
   attempt_outcome_type want;
   attempt_outcome_type got;
   int                  mismatches = 0;
   logic [1:0]          csr_index;

   assign csr_index = paddr[3:2];

   // Refill from elapsed time, then take one whole token if there is one
   function automatic attempt_outcome_type settle_attempt(
      input logic [tbrl_pkg::TIME_W-1:0] now);
      logic [63:0]         elapsed;
      logic [63:0]         amount;
      logic [63:0]         top;
      logic [63:0]         cur;
      logic [127:0]        product;
      attempt_outcome_type r;
      top = 64'(capacity_cfg) << tbrl_pkg::SCALE_SHIFT;
      cur = 64'(level);
      if (now > refill_ns) begin
         elapsed = now - refill_ns;
         product = 128'(elapsed) * 128'(rate_cfg);
         if (product[127:64] != '0) begin
            product = {64'd0, {64{1'b1}}};
         end
         amount = product[63:0] >> tbrl_pkg::SCALE_SHIFT;
         // Keep the refill time on a zero amount so fractions accrue
         if (amount != '0) begin
            refill_ns = now;
            if (cur >= top || amount >= top - cur) begin
               cur = top;
            end else begin
               cur = cur + amount;
            end
         end
      end
      r = '0;
      if (cur >= 64'(tbrl_pkg::SCALE_UNIT)) begin
         r.granted = 1'b1;
         if (burst_cfg && cur > (top >> 1)) begin
            r.was_burst = 1'b1;
            burst_n     = burst_n + tbrl_pkg::COUNT_W'(1);
         end
         cur       = cur - 64'(tbrl_pkg::SCALE_UNIT);
         allowed_n = allowed_n + tbrl_pkg::COUNT_W'(1);
      end else begin
         denied_n = denied_n + tbrl_pkg::COUNT_W'(1);
      end
      level           = tbrl_pkg::LEVEL_W'(cur);
      r.tokens_whole  = tbrl_pkg::CAP_W'(cur >> tbrl_pkg::SCALE_SHIFT);
      r.allowed_total = allowed_n;
      r.denied_total  = denied_n;
      r.burst_total   = burst_n;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rate_cfg     = '0;
         capacity_cfg = tbrl_pkg::CAP_RESET;
         burst_cfg    = 1'b1;
         level        = tbrl_pkg::LEVEL_RESET;
         refill_ns    = '0;
         allowed_n    = '0;
         denied_n     = '0;
         burst_n      = '0;
         outcome_q.delete();
      end else begin
         // Track register writes; unmapped indexes are dropped
         if (psel && penable && pwrite && pready) begin
            case (csr_index)
               tbrl_pkg::REG_RATE:     rate_cfg     = pwdata[tbrl_pkg::RATE_W-1:0];
               tbrl_pkg::REG_CAPACITY: capacity_cfg = pwdata[tbrl_pkg::CAP_W-1:0];
               tbrl_pkg::REG_BURST:    burst_cfg    = pwdata[0];
               default: ;
            endcase
         end

         // Predict each accepted request beat
         if (req_valid && !req_stall) begin
            outcome_q.push_back(settle_attempt(req_now_ns));
         end

         // Compare each accepted response beat with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_granted, rsp_was_burst, rsp_tokens_whole,
                   rsp_allowed_total, rsp_denied_total, rsp_burst_total};
            if (outcome_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: response beat with no request pending: granted=%0d",
                           $time, got.granted);
               end
            end else begin
               want = outcome_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: exp granted=%0d burst=%0d tokens=%0d allowed=%0d %s",
                              $time, want.granted, want.was_burst, want.tokens_whole,
                              want.allowed_total, "");
                     $display("   exp denied=%0d bursts=%0d", want.denied_total,
                              want.burst_total);
                     $display("   got granted=%0d burst=%0d tokens=%0d allowed=%0d",
                              got.granted, got.was_burst, got.tokens_whole,
                              got.allowed_total);
                     $display("   got denied=%0d bursts=%0d", got.denied_total,
                              got.burst_total);
                  end
               end
            end
         end
      end
      pending_count  <= outcome_q.size();
      mismatch_count <= mismatches;
   end

endmodule

/* dv/token_bucket_rate_limiter_tb.sv */
// Testbench top: clock, reset, request and register stimulus, response stalls and verdict.
`timescale 1ns / 1ps

module token_bucket_rate_limiter_tb;

   localparam int         CYCLE_LIMIT    = 200000;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         PHASE_ITEMS    = 80;
   localparam logic [1:0] UNMAPPED_INDEX = 2'd3;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [tbrl_pkg::TIME_W-1:0]     req_now_ns = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_granted;
   logic                            rsp_was_burst;
   logic [tbrl_pkg::CAP_W-1:0]      rsp_tokens_whole;
   logic [tbrl_pkg::COUNT_W-1:0]    rsp_allowed_total;
   logic [tbrl_pkg::COUNT_W-1:0]    rsp_denied_total;
   logic [tbrl_pkg::COUNT_W-1:0]    rsp_burst_total;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [tbrl_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]                     pwdata = '0;
   logic [31:0]                     prdata;
   logic                            pready;

   int                              mismatch_count;
   int                              pending_count;
   int                              cycle_count = 0;
   bit                              quiet = 1'b0;
   bit                              hold_rsp = 1'b0;
   logic [tbrl_pkg::TIME_W-1:0]     stamp;

   token_bucket_rate_limiter dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_now_ns        (req_now_ns),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted       (rsp_granted),
      .rsp_was_burst     (rsp_was_burst),
      .rsp_tokens_whole  (rsp_tokens_whole),
      .rsp_allowed_total (rsp_allowed_total),
      .rsp_denied_total  (rsp_denied_total),
      .rsp_burst_total   (rsp_burst_total),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   tbrl_grant_checker grant_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_now_ns        (req_now_ns),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_granted       (rsp_granted),
      .rsp_was_burst     (rsp_was_burst),
      .rsp_tokens_whole  (rsp_tokens_whole),
      .rsp_allowed_total (rsp_allowed_total),
      .rsp_denied_total  (rsp_denied_total),
      .rsp_burst_total   (rsp_burst_total),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .mismatch_count    (mismatch_count),
      .pending_count     (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Bound the run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Drive response stall: random, quiet stretches, and one long hold-off
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < 9);
         end
      end
   end

   // Offer one attempt beat and hold it until accepted
   task automatic offer_attempt(input logic [tbrl_pkg::TIME_W-1:0] now);
      while (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_now_ns <= now;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop offering and wait until every prediction has been matched
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the access edge
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= tbrl_pkg::CSR_ADDR_W'({index, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [tbrl_pkg::TIME_W-1:0] pick_step();
      int sel;
      sel = $urandom_range(99);
      if (sel < 10) return '0;
      if (sel < 60) return tbrl_pkg::TIME_W'($urandom_range(1, 64));
      if (sel < 85) return tbrl_pkg::TIME_W'($urandom_range(1, 4096));
      if (sel < 95) return tbrl_pkg::TIME_W'($urandom_range(1, 1 << 22));
      return tbrl_pkg::TIME_W'({8'($urandom), 32'($urandom)});
   endfunction

   function automatic logic [tbrl_pkg::RATE_W-1:0] pick_rate();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return tbrl_pkg::RATE_W'($urandom);
         default: return tbrl_pkg::RATE_W'($urandom_range(1 << 12, 1 << 19));
      endcase
   endfunction

   function automatic logic [tbrl_pkg::CAP_W-1:0] pick_capacity();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         2: return tbrl_pkg::CAP_W'($urandom_range(1, 2));
         default: return tbrl_pkg::CAP_W'($urandom_range(3, 24));
      endcase
   endfunction

   // One setting: random registers, then mostly forward-moving attempts
   task automatic run_phase(input int count);
      logic [tbrl_pkg::TIME_W-1:0] back;
      csr_write(tbrl_pkg::REG_RATE, pick_rate());
      csr_write(tbrl_pkg::REG_CAPACITY, {16'($urandom), pick_capacity()});
      csr_write(tbrl_pkg::REG_BURST, {31'($urandom), 1'($urandom)});
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain();
         if ($urandom_range(99) < 6) begin
            // Step back in time; the bucket must ignore the stamp
            back = tbrl_pkg::TIME_W'($urandom_range(0, 5000));
            offer_attempt((stamp > back) ? stamp - back : '0);
         end else begin
            stamp = stamp + pick_step();
            offer_attempt(stamp);
         end
      end
      drain();
   endtask

   initial begin
      logic [tbrl_pkg::TIME_W-1:0] base;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: full bucket, zero rate, bursts above five tokens
      offer_attempt('0);
      offer_attempt('0);
      offer_attempt('0);
      offer_attempt(tbrl_pkg::TIME_W'(100));
      drain();

      // Widest rate and capacity; oversized product fills the bucket; masked burst bit
      csr_write(tbrl_pkg::REG_RATE, 32'hFFFF_FFFF);
      csr_write(tbrl_pkg::REG_CAPACITY, 32'hFFFF_FFFF);
      csr_write(tbrl_pkg::REG_BURST, 32'hFFFF_FFFE);
      csr_write(UNMAPPED_INDEX, $urandom);
      base = tbrl_pkg::TIME_W'(1) << 40;
      offer_attempt(base);
      offer_attempt(base);
      drain();

      // Lower capacity: level stays until the next nonzero refill clips it
      csr_write(tbrl_pkg::REG_CAPACITY, 32'd2);
      csr_write(tbrl_pkg::REG_BURST, 32'd1);
      offer_attempt(base);
      offer_attempt(base + 1);
      drain();

      // Zero capacity empties the bucket on refill
      csr_write(tbrl_pkg::REG_CAPACITY, 32'd0);
      offer_attempt(base + 2);
      offer_attempt(base + 2);
      drain();

      // Slowest rate: zero amounts keep the refill time, fractions accrue
      csr_write(tbrl_pkg::REG_RATE, 32'd1);
      csr_write(tbrl_pkg::REG_CAPACITY, 32'd1);
      offer_attempt(base + 1000);
      offer_attempt(base + (tbrl_pkg::TIME_W'(1) << 20) + 2);
      drain();

      // One level unit (2^-20 token) per ns into a three-token bucket, then attempts at one stamp
      csr_write(tbrl_pkg::REG_RATE, 32'h0010_0000);
      csr_write(tbrl_pkg::REG_CAPACITY, 32'd3);
      stamp = base + (tbrl_pkg::TIME_W'(1) << 20) + 7;
      repeat (4) offer_attempt(stamp);
      drain();

      // Random settings; long receiver hold-off first, one stretch with no idling
      hold_rsp = 1'b1;
      run_phase(PHASE_ITEMS);
      run_phase(PHASE_ITEMS);
      quiet = 1'b1;
      run_phase(PHASE_ITEMS);
      quiet = 1'b0;
      repeat (4) run_phase(PHASE_ITEMS);

      // Top of the time range, last since refill time can no longer advance
      stamp = {1'b1, 63'({$urandom, $urandom})};
      run_phase(PHASE_ITEMS);
      offer_attempt('1);
      repeat (4) offer_attempt({$urandom, $urandom});
      drain();
      repeat (5) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
